[hdl/ttws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttws_pkg: shared types and constants for the tick timer wakeup scheduler
// Opcodes, result kinds, table sizes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ttws_pkg;

	localparam int SleepSlots = 16;
	localparam int JobSlots   = 16;
	localparam int MaxResults = 32;
	localparam int SW = (SleepSlots > 1) ? $clog2(SleepSlots) : 1;
	localparam int JW = (JobSlots > 1) ? $clog2(JobSlots) : 1;
	localparam int CntW = $clog2(MaxResults + 1);

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_TIME   = 3'd1;
	localparam logic [2:0] OP_DELAY  = 3'd2;
	localparam logic [2:0] OP_UNTIL  = 3'd3;
	localparam logic [2:0] OP_SCHED  = 3'd4;

	localparam logic [2:0] K_WAKE    = 3'd0;
	localparam logic [2:0] K_TIME    = 3'd1;
	localparam logic [2:0] K_DELIVER = 3'd2;
	localparam logic [2:0] K_ACK     = 3'd3;
	localparam logic [2:0] K_ERROR   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_S,
		ST_POP_S,
		ST_SCAN_J,
		ST_POP_J,
		ST_EMIT,
		ST_EMIT2
	} state_t;

	// Result source selected by the controller
	typedef enum logic [2:0] {
		RS_WAKE_REQ,
		RS_TIME_REQ,
		RS_ERR_REQ,
		RS_ACK_REQ,
		RS_DELIV_IN,
		RS_WAKE_SLOT,
		RS_DELIV_SLOT
	} rsel_t;

	typedef struct packed {
		logic  load;       // capture input transaction
		logic  tick;       // advance counter
		logic  store_s;    // write sleep entry at free slot
		logic  store_j;    // write job entry at free slot
		logic  scan_clr;   // restart a table scan
		logic  scan_s;     // step sleep scan
		logic  scan_j;     // step job scan
		logic  pop_s;      // release found sleeper
		logic  pop_j;      // release found job
		logic  emit;       // load output register
		logic  flush;      // release held tick result as the last one
		rsel_t rsel;
		logic  rlast;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       tv_zero;    // tick_value is zero
		logic       until_past; // tick_value at or below counter
		logic       s_free;     // a sleep slot is free
		logic       j_free;     // a job slot is free
		logic       scan_done;
		logic       found;      // scan found a due entry
		logic       out_busy;   // output register holds a result not taken this cycle
	} sts_t;

endpackage

[hdl/ttws_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttws_ctrl: operation sequencer
// Decodes one transaction, steps table scans and orders the results.
// ----------------------------------------------------------------------------
module ttws_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ttws_pkg::sts_t  sts,
	output ttws_pkg::cmd_t  cmd
);
	import ttws_pkg::*;

	state_t state_q, state_nx;
	logic [CntW-1:0] n_q, n_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
		end else begin
			state_q <= state_nx;
			n_q <= n_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		n_nx = n_q;
		cmd = '0;
		cmd.rsel = RS_ERR_REQ;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
					cmd.rlast = 1'b1;
					case (sts.op)
						OP_TICK: begin
							cmd.tick = 1'b1;
							cmd.scan_clr = 1'b1;
							n_nx = '0;
							state_nx = ST_SCAN_S;
						end
						OP_TIME: begin
							cmd.emit = 1'b1;
							cmd.rsel = RS_TIME_REQ;
						end
						OP_DELAY, OP_UNTIL: begin
							if ((sts.op == OP_DELAY && sts.tv_zero) ||
									(sts.op == OP_UNTIL && sts.until_past)) begin
								cmd.emit = 1'b1;
								cmd.rsel = RS_WAKE_REQ;
							end else if (!sts.s_free) begin
								cmd.emit = 1'b1;
								cmd.rsel = RS_ERR_REQ;
							end else begin
								cmd.store_s = 1'b1;
							end
						end
						OP_SCHED: begin
							cmd.emit = 1'b1;
							if (sts.tv_zero) begin
								cmd.rsel = RS_DELIV_IN;
								cmd.rlast = 1'b0;
								state_nx = ST_EMIT2;
							end else if (!sts.j_free) begin
								cmd.rsel = RS_ERR_REQ;
							end else begin
								cmd.store_j = 1'b1;
								cmd.rsel = RS_ACK_REQ;
							end
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.rsel = RS_ERR_REQ;
						end
					endcase
				end
			end
			ST_EMIT2: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.rsel = RS_ACK_REQ;
					cmd.rlast = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_SCAN_S: begin
				if (sts.scan_done) begin
					cmd.scan_clr = 1'b1;
					state_nx = (sts.found && n_q != CntW'(MaxResults)) ? ST_POP_S : ST_SCAN_J;
				end else begin
					cmd.scan_s = 1'b1;
				end
			end
			ST_POP_S: begin
				if (!sts.out_busy) begin
					cmd.pop_s = 1'b1;
					cmd.emit = 1'b1;
					cmd.rsel = RS_WAKE_SLOT;
					n_nx = n_q + 1'b1;
					state_nx = ST_SCAN_S;
				end
			end
			ST_SCAN_J: begin
				if (sts.scan_done) begin
					cmd.scan_clr = 1'b1;
					state_nx = (sts.found && n_q != CntW'(MaxResults)) ? ST_POP_J : ST_EMIT;
				end else begin
					cmd.scan_j = 1'b1;
				end
			end
			ST_POP_J: begin
				if (!sts.out_busy) begin
					cmd.pop_j = 1'b1;
					cmd.emit = 1'b1;
					cmd.rsel = RS_DELIV_SLOT;
					n_nx = n_q + 1'b1;
					state_nx = ST_SCAN_J;
				end
			end
			// Tick finished: the last result is held back one step so
			// its last flag can be set; release it once the output frees up.
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.flush = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

[hdl/ttws_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttws_dp: scheduler datapath
// Counter, sleep and job tables, serial due-entry scan and output register
// with a one-entry hold so the final tick result carries its last flag.
// ----------------------------------------------------------------------------
module ttws_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ttws_pkg::cmd_t  cmd,
	output ttws_pkg::sts_t  sts,
	input  logic [2:0]      in_op,
	input  logic [7:0]      in_req,
	input  logic [31:0]     in_tv,
	input  logic [7:0]      in_tgt,
	input  logic [31:0]     in_pay,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      out_kind,
	output logic [7:0]      out_dest,
	output logic [31:0]     out_value,
	output logic            out_last
);
	import ttws_pkg::*;

	logic [2:0]  op_q;
	logic [7:0]  req_q, tgt_q;
	logic [31:0] tv_q, pay_q, now_q;

	logic [31:0] s_time [SleepSlots];
	logic [7:0]  s_task [SleepSlots];
	logic [SleepSlots-1:0] s_vld_q;
	logic [31:0] j_time [JobSlots];
	logic [7:0]  j_dst  [JobSlots];
	logic [31:0] j_dat  [JobSlots];
	logic [JobSlots-1:0] j_vld_q;

	// Scan state
	localparam int IW = (SW > JW) ? SW : JW;
	logic [IW:0]   idx_q;
	logic [IW-1:0] best_q;
	logic [31:0]   best_t_q;
	logic          found_q;

	// Output holding: pending result waits for the next one or for end of tick
	logic        hv_q;
	logic [2:0]  hk_q;
	logic [7:0]  hd_q;
	logic [31:0] hval_q;
	logic        ov_q;

	// Capture input
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op; req_q <= in_req; tv_q <= in_tv;
			tgt_q <= in_tgt; pay_q <= in_pay;
		end
	end

	// Relative deadline with saturation
	logic [32:0] dl_sum;
	logic [31:0] dl;
	assign dl_sum = {1'b0, now_q} + {1'b0, tv_q};
	assign dl = dl_sum[32] ? '1 : dl_sum[31:0];

	// Lowest free slots
	logic [SW-1:0] s_free_i;
	logic [JW-1:0] j_free_i;
	always_comb begin
		s_free_i = '0;
		for (int i = SleepSlots - 1; i >= 0; i--)
			if (!s_vld_q[i]) s_free_i = SW'(i);
		j_free_i = '0;
		for (int i = JobSlots - 1; i >= 0; i--)
			if (!j_vld_q[i]) j_free_i = JW'(i);
	end

	// Counter and tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			s_vld_q <= '0;
			j_vld_q <= '0;
		end else begin
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.store_s) s_vld_q[s_free_i] <= 1'b1;
			if (cmd.store_j) j_vld_q[j_free_i] <= 1'b1;
			if (cmd.pop_s) s_vld_q[best_q[SW-1:0]] <= 1'b0;
			if (cmd.pop_j) j_vld_q[best_q[JW-1:0]] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_s) begin
			s_time[s_free_i] <= (op_q == OP_DELAY) ? dl : tv_q;
			s_task[s_free_i] <= req_q;
		end
		if (cmd.store_j) begin
			j_time[j_free_i] <= dl;
			j_dst[j_free_i] <= tgt_q;
			j_dat[j_free_i] <= pay_q;
		end
	end

	// Serial scan, one slot per cycle
	logic          cur_v;
	logic [31:0]   cur_t;
	logic [IW:0]   lim;
	logic          scan_s_act_q;
	always_comb begin
		cur_v = 1'b0;
		cur_t = '0;
		if (cmd.scan_s) begin
			cur_v = s_vld_q[idx_q[SW-1:0]];
			cur_t = s_time[idx_q[SW-1:0]];
		end else if (cmd.scan_j) begin
			cur_v = j_vld_q[idx_q[JW-1:0]];
			cur_t = j_time[idx_q[JW-1:0]];
		end
	end

	// End of the table being walked
	assign lim = scan_s_act_q ? (IW+1)'(SleepSlots) : (IW+1)'(JobSlots);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			scan_s_act_q <= 1'b1;
		end else if (cmd.scan_clr) begin
			idx_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_s || cmd.scan_j) begin
			scan_s_act_q <= cmd.scan_s;
			idx_q <= idx_q + 1'b1;
			if (cur_v && cur_t <= now_q && (!found_q || cur_t < best_t_q)) begin
				found_q <= 1'b1;
				best_q <= idx_q[IW-1:0];
				best_t_q <= cur_t;
			end
		end
	end

	// Output path: a new tick result pushes the held one to the output register; others go straight there
	logic        push;
	logic [2:0]  nk;
	logic [7:0]  nd;
	logic [31:0] nv;
	always_comb begin
		nk = K_ERROR; nd = req_q; nv = '0;
		case (cmd.rsel)
			RS_WAKE_REQ:   begin nk = K_WAKE; nv = now_q; end
			RS_TIME_REQ:   begin nk = K_TIME; nv = now_q; end
			RS_ACK_REQ:    nk = K_ACK;
			RS_DELIV_IN:   begin nk = K_DELIVER; nd = tgt_q; nv = pay_q; end
			RS_WAKE_SLOT:  begin nk = K_WAKE; nd = s_task[best_q[SW-1:0]]; nv = now_q; end
			RS_DELIV_SLOT: begin
				nk = K_DELIVER; nd = j_dst[best_q[JW-1:0]]; nv = j_dat[best_q[JW-1:0]];
			end
			default: ;
		endcase
	end

	logic tick_emit, tick_end;
	assign tick_emit = cmd.pop_s || cmd.pop_j;
	assign tick_end = cmd.flush && hv_q;
	assign push = (cmd.emit && !tick_emit) || (tick_emit && hv_q) || tick_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			hv_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (push) ov_q <= 1'b1;
			if (tick_emit) hv_q <= 1'b1;
			else if (tick_end) hv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_emit) begin
			hk_q <= nk; hd_q <= nd; hval_q <= nv;
		end
		if (push) begin
			if (cmd.emit && !tick_emit) begin
				out_kind <= nk; out_dest <= nd; out_value <= nv; out_last <= cmd.rlast;
			end else begin
				out_kind <= hk_q; out_dest <= hd_q; out_value <= hval_q; out_last <= tick_end;
			end
		end
	end

	assign out_valid = ov_q;

	// Status
	always_comb begin
		sts.op = op_q;
		sts.tv_zero = (tv_q == '0);
		sts.until_past = (tv_q <= now_q);
		sts.s_free = ~&s_vld_q;
		sts.j_free = ~&j_vld_q;
		sts.scan_done = (idx_q == lim);
		sts.found = found_q;
		sts.out_busy = ov_q && !out_ready;
	end

endmodule

[hdl/tick_timer_wakeup_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_timer_wakeup_scheduler_top: tick timer with sleep and job tables
// Counts ticks, parks sleepers and jobs, releases due sleepers, then due jobs, each in wake order.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tuser = op; tdata = requester_id, tick_value,
//                                       target, payload
// m_axis   out  m_axis_tvalid/tready    tuser = kind; tdata = dest_id, value; tlast = last
//
// One transaction at a time. A tick walks the sleep table once per released
// entry plus one final pass, then the job table the same way. The output
// register holds one result; the sequencer stalls on m_axis_tready, and a
// tick ends only once its last result is out.
// Reset (arst_n) clears the counter and both valid vectors.
// ----------------------------------------------------------------------------
module tick_timer_wakeup_scheduler_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // requester_id[7:0] tick_value[39:8] job_target[47:40] job_payload[79:48]
	input  logic [2:0]   s_axis_tuser,  // op[2:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,  // dest_id[7:0] value[39:8]
	output logic [2:0]   m_axis_tuser,  // kind[2:0]
	output logic         m_axis_tlast
);
	import ttws_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [2:0]  kind;
	logic [7:0]  dest_id;
	logic [31:0] value;

	ttws_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	ttws_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(s_axis_tuser), .in_req(s_axis_tdata[7:0]),
		.in_tv(s_axis_tdata[39:8]), .in_tgt(s_axis_tdata[47:40]),
		.in_pay(s_axis_tdata[79:48]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(kind), .out_dest(dest_id), .out_value(value), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {value, dest_id};
	assign m_axis_tuser = kind;

	// Scan and release never overlap the input side
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_s || cmd.pop_s || cmd.scan_j || cmd.pop_j) |-> !s_axis_tready)
		else $error("input accepted during tick walk");

	a_one_release: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop_s && cmd.pop_j))
		else $error("two releases in one cycle");

	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_s |-> !cmd.store_j && !cmd.emit)
		else $error("sleep store with a result");

endmodule

[bench/tick_timer_wakeup_scheduler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_timer_wakeup_scheduler_top_tb: self-checking bench for the tick timer
// A directed table covers immediate answers, invalid ops, saturated deadlines
// and releases; a random part follows. Every result is compared against a
// local model of the counter and both tables, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tick_timer_wakeup_scheduler_top_tb;
	import ttws_pkg::*;

	localparam logic [2:0] OP_INV5 = 3'd5;
	localparam logic [2:0] OP_INV6 = 3'd6;
	localparam logic [2:0] OP_INV7 = 3'd7;
	localparam int RAND_ITEMS = 250;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  dest;
		logic [31:0] value;
		logic        last;
	} result_t;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  req;
		logic [31:0] tv;
		logic [7:0]  tgt;
		logic [31:0] pay;
		bit          typed;
		logic [2:0]  ekind;
		logic [7:0]  edest;
		logic [31:0] evalue;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// model state
	logic [31:0] mdl_now;
	logic [31:0] mdl_s_wake [SleepSlots];
	logic [7:0]  mdl_s_task [SleepSlots];
	bit          mdl_s_valid [SleepSlots];
	logic [31:0] mdl_j_wake [JobSlots];
	logic [7:0]  mdl_j_dest [JobSlots];
	logic [31:0] mdl_j_data [JobSlots];
	bit          mdl_j_used [JobSlots];

	result_t   pending_results[$];
	int        err_count = 0;
	int        results_seen = 0;
	int        idle_cycles = 0;
	int        items_sent = 0;
	int        rx_stall = 0;
	int        rx_hold = 0;
	bit        rx_held = 1'b0;
	stim_row_t dir_tab [16];

	tick_timer_wakeup_scheduler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] sat_deadline(input logic [31:0] rel);
		logic [32:0] sum;
		sum = {1'b0, mdl_now} + {1'b0, rel};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	task automatic push_result(input logic [2:0] k, input logic [7:0] d, input logic [31:0] v);
		result_t r;
		r.kind = k;
		r.dest = d;
		r.value = v;
		r.last = 1'b0;
		pending_results.push_back(r);
	endtask

	// Advance the model by one operation and queue the results it causes
	task automatic sched_predict(input logic [2:0] op, input logic [7:0] req,
			input logic [31:0] tv, input logic [7:0] tgt, input logic [31:0] pay);
		int n;
		int best;
		int slot;
		n = 0;
		case (op)
			OP_TICK: begin
				mdl_now = mdl_now + 32'd1;
				// sleepers first, earliest wake time, lowest slot on ties
				do begin
					best = -1;
					for (int i = 0; i < SleepSlots; i++)
						if (mdl_s_valid[i] && mdl_s_wake[i] <= mdl_now &&
								(best < 0 || mdl_s_wake[i] < mdl_s_wake[best]))
							best = i;
					if (best >= 0 && n < MaxResults) begin
						mdl_s_valid[best] = 1'b0;
						push_result(K_WAKE, mdl_s_task[best], mdl_now);
						n++;
					end
				end while (best >= 0 && n < MaxResults);
				do begin
					best = -1;
					for (int i = 0; i < JobSlots; i++)
						if (mdl_j_used[i] && mdl_j_wake[i] <= mdl_now &&
								(best < 0 || mdl_j_wake[i] < mdl_j_wake[best]))
							best = i;
					if (best >= 0 && n < MaxResults) begin
						mdl_j_used[best] = 1'b0;
						push_result(K_DELIVER, mdl_j_dest[best], mdl_j_data[best]);
						n++;
					end
				end while (best >= 0 && n < MaxResults);
			end
			OP_TIME: begin
				push_result(K_TIME, req, mdl_now);
				n++;
			end
			OP_DELAY, OP_UNTIL: begin
				if ((op == OP_DELAY && tv == 0) || (op == OP_UNTIL && tv <= mdl_now)) begin
					push_result(K_WAKE, req, mdl_now);
					n++;
				end else begin
					slot = -1;
					for (int i = SleepSlots - 1; i >= 0; i--)
						if (!mdl_s_valid[i]) slot = i;
					if (slot < 0) begin
						push_result(K_ERROR, req, 32'd0);
						n++;
					end else begin
						mdl_s_wake[slot] = (op == OP_DELAY) ? sat_deadline(tv) : tv;
						mdl_s_task[slot] = req;
						mdl_s_valid[slot] = 1'b1;
					end
				end
			end
			OP_SCHED: begin
				if (tv == 0) begin
					push_result(K_DELIVER, tgt, pay);
					push_result(K_ACK, req, 32'd0);
					n += 2;
				end else begin
					slot = -1;
					for (int i = JobSlots - 1; i >= 0; i--)
						if (!mdl_j_used[i]) slot = i;
					if (slot < 0) begin
						push_result(K_ERROR, req, 32'd0);
					end else begin
						mdl_j_wake[slot] = sat_deadline(tv);
						mdl_j_dest[slot] = tgt;
						mdl_j_data[slot] = pay;
						mdl_j_used[slot] = 1'b1;
						push_result(K_ACK, req, 32'd0);
					end
					n++;
				end
			end
			default: begin
				push_result(K_ERROR, req, 32'd0);
				n++;
			end
		endcase
		if (n > 0)
			pending_results[$].last = 1'b1;
	endtask

	// Offer one transaction after a gap, wait for acceptance, then predict
	task automatic send_op(input stim_row_t row, input int gap);
		int qs;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row.pay, row.tgt, row.tv, row.req};
		s_axis_tuser <= row.op;
		do @(posedge clk); while (!s_axis_tready);
		qs = pending_results.size();
		sched_predict(row.op, row.req, row.tv, row.tgt, row.pay);
		if (row.typed) begin
			if (pending_results.size() != qs + 1)
				report_mismatch("directed row did not give a single result");
			else begin
				pending_results[$].kind = row.ekind;
				pending_results[$].dest = row.edest;
				pending_results[$].value = row.evalue;
			end
		end
		items_sent++;
	endtask

	function automatic stim_row_t mk_row(input logic [2:0] op, input logic [7:0] req,
			input logic [31:0] tv, input logic [7:0] tgt, input logic [31:0] pay,
			input bit typed, input logic [2:0] ek, input logic [31:0] ev);
		stim_row_t r;
		r.op = op; r.req = req; r.tv = tv; r.tgt = tgt; r.pay = pay;
		r.typed = typed; r.ekind = ek; r.edest = req; r.evalue = ev;
		return r;
	endfunction

	function automatic stim_row_t rand_row();
		stim_row_t r;
		int pick;
		r = mk_row(OP_TICK, 8'($urandom), $urandom, 8'($urandom), $urandom,
			1'b0, K_WAKE, 32'd0);
		pick = $urandom_range(0, 99);
		if (pick < 35) r.op = OP_TICK;
		else if (pick < 40) r.op = OP_TIME;
		else if (pick < 60) r.op = OP_DELAY;
		else if (pick < 75) r.op = OP_UNTIL;
		else if (pick < 95) r.op = OP_SCHED;
		else r.op = 3'($urandom_range(OP_INV5, OP_INV7));
		pick = $urandom_range(0, 9);
		if (r.op == OP_UNTIL) begin
			if (pick < 6) r.tv = mdl_now + $urandom_range(1, 12);
			else if (pick < 8) r.tv = $urandom_range(0, mdl_now);
		end else if (r.op == OP_DELAY || r.op == OP_SCHED) begin
			if (pick < 1) r.tv = 32'd0;
			else if (pick < 8) r.tv = $urandom_range(1, 12);
		end
		return r;
	endfunction

	// Result side: random stalls, one long hold-off, checks on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (pending_results.size() == 0)
					report_mismatch($sformatf("unexpected result %h %h",
						m_axis_tuser, m_axis_tdata));
				else begin
					if (m_axis_tuser !== pending_results[0].kind)
						report_mismatch($sformatf("kind %0d exp %0d",
							m_axis_tuser, pending_results[0].kind));
					if (m_axis_tdata[7:0] !== pending_results[0].dest)
						report_mismatch($sformatf("dest %0d exp %0d",
							m_axis_tdata[7:0], pending_results[0].dest));
					if (m_axis_tdata[39:8] !== pending_results[0].value)
						report_mismatch($sformatf("value %h exp %h",
							m_axis_tdata[39:8], pending_results[0].value));
					if (m_axis_tlast !== pending_results[0].last)
						report_mismatch($sformatf("last %b exp %b",
							m_axis_tlast, pending_results[0].last));
					void'(pending_results.pop_front());
				end
			end
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (!rx_held && items_sent >= 60) begin
				rx_held <= 1'b1;
				rx_hold <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (results_seen < 100 || results_seen >= 160) begin
				rx_stall <= pick_gap();
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		mdl_now = '0;
		foreach (mdl_s_valid[i]) mdl_s_valid[i] = 1'b0;
		foreach (mdl_j_used[i]) mdl_j_used[i] = 1'b0;

		// directed: immediate answers, invalid ops, saturation, releases
		dir_tab[0]  = mk_row(OP_TIME,  8'h00, 32'h0, 8'h00, 32'h0, 1'b1, K_TIME, 0);
		dir_tab[1]  = mk_row(OP_INV5,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
			1'b1, K_ERROR, 0);
		dir_tab[2]  = mk_row(OP_INV6,  8'h5A, 32'h0, 8'h00, 32'h0, 1'b1, K_ERROR, 0);
		dir_tab[3]  = mk_row(OP_INV7,  8'hA5, 32'h1, 8'h00, 32'h0, 1'b1, K_ERROR, 0);
		dir_tab[4]  = mk_row(OP_DELAY, 8'h12, 32'h0, 8'h00, 32'h0, 1'b1, K_WAKE, 0);
		dir_tab[5]  = mk_row(OP_UNTIL, 8'h13, 32'h0, 8'h00, 32'h0, 1'b1, K_WAKE, 0);
		dir_tab[6]  = mk_row(OP_SCHED, 8'h14, 32'h0, 8'hFF, 32'hFFFF_FFFF, 1'b0, K_WAKE, 0);
		dir_tab[7]  = mk_row(OP_DELAY, 8'h01, 32'h1, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[8]  = mk_row(OP_UNTIL, 8'h02, 32'h2, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[9]  = mk_row(OP_DELAY, 8'h03, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[10] = mk_row(OP_SCHED, 8'h04, 32'h1, 8'h07, 32'hDEAD_BEEF, 1'b0, K_WAKE, 0);
		dir_tab[11] = mk_row(OP_SCHED, 8'h05, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[12] = mk_row(OP_DELAY, 8'h06, 32'h1, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[13] = mk_row(OP_TICK,  8'h00, 32'h0, 8'h00, 32'h0, 1'b0, K_WAKE, 0);
		dir_tab[14] = mk_row(OP_TICK,  8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
			1'b0, K_WAKE, 0);
		dir_tab[15] = mk_row(OP_TIME,  8'hFF, 32'h0, 8'h00, 32'h0, 1'b0, K_WAKE, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_op(dir_tab[i], pick_gap());

		// fill both tables to reach the full-table errors
		for (int i = 0; i < SleepSlots + 1; i++)
			send_op(mk_row(OP_DELAY, 8'($urandom), $urandom_range(2, 30), 8'd0, 32'd0,
				1'b0, K_WAKE, 32'd0), 0);
		for (int i = 0; i < JobSlots + 1; i++)
			send_op(mk_row(OP_SCHED, 8'($urandom), $urandom_range(2, 30), 8'($urandom),
				$urandom, 1'b0, K_WAKE, 32'd0), 0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 150) begin
				s_axis_tvalid <= 1'b0;
				wait (pending_results.size() == 0);
				@(posedge clk);
			end
			send_op(rand_row(), (i >= 200 && i < 240) ? 0 : pick_gap());
		end
		s_axis_tvalid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
